>>> design/mtrg_pkg.sv
// Shared constants, controller states and command/status groups for the MT19937 generator.
`default_nettype none
package mtrg_pkg;

	localparam int          STATE_WORDS  = 624;
	localparam int          TWIST_OFFSET = 397;
	localparam logic [31:0] TWIST_MATRIX = 32'h9908_b0df;
	localparam logic [31:0] HIGH_BIT     = 32'h8000_0000;
	localparam logic [31:0] LOW_BITS     = 32'h7fff_ffff;
	localparam logic [31:0] TEMPER_B     = 32'h9d2c_5680;
	localparam logic [31:0] TEMPER_C     = 32'hefc6_0000;
	localparam logic [31:0] SEED_MULT    = 32'd69069;
	localparam logic [31:0] DEFAULT_SEED = 32'd4357;

	localparam logic OP_DRAW = 1'b0;
	localparam logic OP_SEED = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SEED,
		ST_TW_RD0,
		ST_TW_LD,
		ST_TW_NEXT,
		ST_TW_FAR,
		ST_TW_WR,
		ST_DRAW_RD,
		ST_DRAW_OUT
	} mtrg_state_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic seed_load_user;
		logic seed_load_default;
		logic seed_step;
		logic tw_rd_zero;
		logic tw_load_cur;
		logic tw_rd_next;
		logic tw_rd_far;
		logic tw_write;
		logic draw_rd;
		logic draw_out;
	} mtrg_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic k_last;
		logic idx_full;
		logic idx_unseeded;
	} mtrg_status_t;

endpackage
`default_nettype wire

>>> design/mtrg_datapath.sv
// Datapath: state word memory, seed recurrence, in-place twist and tempering.
`default_nettype none
module mtrg_datapath
	import mtrg_pkg::*;
#(
	parameter int N_WORDS = STATE_WORDS
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire mtrg_cmd_t    cmd,
	input  wire logic [31:0]  seed_value,
	output mtrg_status_t      status,
	output logic [31:0]       random_word,
	output logic              done
);

	localparam int AW = $clog2(N_WORDS);
	localparam int IW = $clog2(N_WORDS + 2);

	logic [31:0]   mem [N_WORDS];
	logic [31:0]   rdata_q;
	logic [AW-1:0] raddr;
	logic          we;
	logic [AW-1:0] waddr;
	logic [31:0]   wdata;

	logic [31:0]   w_q;
	logic [31:0]   cur_q;
	logic [31:0]   nxt_q;
	logic [AW-1:0] k_q;
	logic [IW-1:0] idx_q;
	logic [31:0]   out_q;
	logic          done_q;

	logic          k_last;
	logic [AW-1:0] k_next;
	logic [AW:0]   far_sum;
	logic [AW-1:0] far_addr;
	logic [AW-1:0] next_addr;
	logic [31:0]   y;
	logic [31:0]   twisted;
	logic [31:0]   w_mult;

	function automatic logic [31:0] temper(input logic [31:0] v);
		logic [31:0] t;
		t = v ^ (v >> 11);
		t = t ^ ((t << 7) & TEMPER_B);
		t = t ^ ((t << 15) & TEMPER_C);
		t = t ^ (t >> 18);
		return t;
	endfunction

	// Address arithmetic for the twist
	assign k_last    = (k_q == AW'(N_WORDS - 1));
	assign k_next    = k_last ? '0 : k_q + AW'(1);
	assign next_addr = k_next;
	assign far_sum   = {1'b0, k_q} + (AW + 1)'(TWIST_OFFSET);
	assign far_addr  = (far_sum >= (AW + 1)'(N_WORDS)) ?
		AW'(far_sum - (AW + 1)'(N_WORDS)) : far_sum[AW-1:0];

	// Twist one word: upper bit of current, lower bits of next, mixed with far word
	assign y       = (cur_q & HIGH_BIT) | (nxt_q & LOW_BITS);
	assign twisted = rdata_q ^ (y >> 1) ^ (y[0] ? TWIST_MATRIX : 32'h0);
	assign w_mult  = w_q * SEED_MULT;

	// Select read address
	always_comb begin
		raddr = '0;
		if (cmd.tw_rd_next) begin
			raddr = next_addr;
		end else if (cmd.tw_rd_far) begin
			raddr = far_addr;
		end else if (cmd.draw_rd) begin
			raddr = idx_q[AW-1:0];
		end
	end

	// Select write port
	always_comb begin
		we    = cmd.seed_step | cmd.tw_write;
		waddr = k_q;
		wdata = cmd.seed_step ? w_q : twisted;
	end

	// Memory: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.seed_load_user) begin
			w_q <= seed_value;
		end else if (cmd.seed_load_default) begin
			w_q <= DEFAULT_SEED;
		end else if (cmd.seed_step) begin
			w_q <= w_mult;
		end
		if (cmd.tw_load_cur) begin
			cur_q <= rdata_q;
		end else if (cmd.tw_write) begin
			cur_q <= nxt_q;
		end
		if (cmd.tw_rd_far) begin
			nxt_q <= rdata_q;
		end
		if (cmd.draw_out) begin
			out_q <= temper(rdata_q);
		end
	end

	// Word counter, read index and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q    <= '0;
			idx_q  <= IW'(N_WORDS + 1);
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.draw_out;
			if (cmd.seed_load_user || cmd.seed_load_default || cmd.tw_rd_zero) begin
				k_q <= '0;
			end else if (cmd.seed_step || cmd.tw_write) begin
				k_q <= k_next;
			end
			if (cmd.seed_step && k_last) begin
				idx_q <= IW'(N_WORDS);
			end else if (cmd.tw_write && k_last) begin
				idx_q <= '0;
			end else if (cmd.draw_out) begin
				idx_q <= idx_q + IW'(1);
			end
		end
	end

	assign status.k_last       = k_last;
	assign status.idx_full     = (idx_q >= IW'(N_WORDS));
	assign status.idx_unseeded = (idx_q != IW'(N_WORDS));
	assign random_word         = out_q;
	assign done                = done_q;

endmodule
`default_nettype wire

>>> design/mtrg_controller.sv
// Controller: sequences seeding, the twist pass and draws.
`default_nettype none
module mtrg_controller
	import mtrg_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic         opcode,
	input  wire mtrg_status_t status,
	output mtrg_cmd_t         cmd,
	output logic              busy
);

	mtrg_state_t state_q;
	mtrg_state_t state_d;
	logic        pend_q;
	logic        pend_d;

	// Next state
	always_comb begin
		state_d = state_q;
		pend_d  = pend_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					priority if (opcode == OP_SEED) begin
						state_d = ST_SEED;
						pend_d  = 1'b0;
					end else if (status.idx_full && status.idx_unseeded) begin
						state_d = ST_SEED;
						pend_d  = 1'b1;
					end else if (status.idx_full) begin
						state_d = ST_TW_RD0;
					end else begin
						state_d = ST_DRAW_RD;
					end
				end
			end
			ST_SEED: begin
				if (status.k_last) begin
					state_d = pend_q ? ST_TW_RD0 : ST_IDLE;
					pend_d  = 1'b0;
				end
			end
			ST_TW_RD0:  state_d = ST_TW_LD;
			ST_TW_LD:   state_d = ST_TW_NEXT;
			ST_TW_NEXT: state_d = ST_TW_FAR;
			ST_TW_FAR:  state_d = ST_TW_WR;
			ST_TW_WR:   state_d = status.k_last ? ST_DRAW_RD : ST_TW_NEXT;
			ST_DRAW_RD: state_d = ST_DRAW_OUT;
			ST_DRAW_OUT: state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// Commands
	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.seed_load_user    = (opcode == OP_SEED);
					cmd.seed_load_default = (opcode == OP_DRAW) && status.idx_full &&
						status.idx_unseeded;
				end
			end
			ST_SEED:     cmd.seed_step   = 1'b1;
			ST_TW_RD0:   cmd.tw_rd_zero  = 1'b1;
			ST_TW_LD:    cmd.tw_load_cur = 1'b1;
			ST_TW_NEXT:  cmd.tw_rd_next  = 1'b1;
			ST_TW_FAR:   cmd.tw_rd_far   = 1'b1;
			ST_TW_WR:    cmd.tw_write    = 1'b1;
			ST_DRAW_RD:  cmd.draw_rd     = 1'b1;
			ST_DRAW_OUT: cmd.draw_out    = 1'b1;
			default:     cmd = '0;
		endcase
	end

	assign busy = (state_q != ST_IDLE);

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_q  <= pend_d;
		end
	end

endmodule
`default_nettype wire

>>> design/mt19937_random_generator.sv
// A draw reads a pool word and strobes it tempered; busy drops as done rises.
// A draw that finds the pool used up first runs the twist: two reads on the
// single read port and one write per word.
// A seed fills the pool with one memory write per word; a draw before
// any seed adds that fill. Reset leaves the pool unseeded; the memory is not
// cleared. Results are strobed for one cycle and cannot be stalled.
`default_nettype none
module mt19937_random_generator
	import mtrg_pkg::*;
#(
	parameter int STATE_WORDS = mtrg_pkg::STATE_WORDS
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        opcode,
	input  wire logic [31:0] seed_value,
	output logic             done,
	output logic [31:0]      random_word
);

	mtrg_cmd_t    cmd;
	mtrg_status_t status;

	mtrg_controller u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.opcode (opcode),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	mtrg_datapath #(
		.N_WORDS (STATE_WORDS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.seed_value  (seed_value),
		.status      (status),
		.random_word (random_word),
		.done        (done)
	);

endmodule
`default_nettype wire
